// ===== hw/rtl/quoted_word_tokenizer_unit_defines.svh =====
// Assertion macros for the word tokenizer checkers.
// Both expect signals named clk and rst in the scope of use.
`ifndef QUOTED_WORD_TOKENIZER_UNIT_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define QWT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication.
`define QWT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== hw/rtl/qwt_pkg.sv =====
`timescale 1ns / 1ps

package qwt_pkg;

  localparam int CHAR_W     = 8;
  localparam int QUOTE_W    = 32;
  localparam int SPACE_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_SLOTS  = 8;
  localparam int SLOT_EXT_W = MAX_SLOTS * CHAR_W;

  localparam logic [CHAR_W-1:0]  NUL_CHAR          = 8'h00;
  localparam logic [CHAR_W-1:0]  ESCAPE_CHAR_RESET = 8'd92;
  localparam logic [QUOTE_W-1:0] QUOTE_CHARS_RESET = 32'h0000_2722;
  localparam logic [SPACE_W-1:0] SPACE_CHARS_RESET = 64'h0000_0000_0D0A_0920;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ESCAPE_CHAR = 2'd0,
    REG_QUOTE_CHARS = 2'd1,
    REG_SPACE_CHARS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] out_char;
    logic              word_done;
  } result_t;

endpackage

// ===== hw/rtl/qwt_if.sv =====
`timescale 1ns / 1ps

interface qwt_in_if;
  import qwt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              is_end;
  modport source (output valid, output ch, output is_end, input ready);
  modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface qwt_out_if;
  import qwt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              word_done;
  modport source (output valid, output out_char, output word_done, input ready);
  modport sink   (input valid, input out_char, input word_done, output ready);
endinterface

interface qwt_cfg_if;
  import qwt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/quoted_word_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// Quoted word tokenizer: splits a byte stream into words, shell style.
// text_in : one beat per character (ch), or an end-of-text beat (is_end, or
//           ch of zero). Escape makes the next byte literal, quotes group
//           bytes up to the same quote byte, whitespace ends words.
// word_out: zero or one beat per input beat: a character appended to the
//           current word (word_done low), or a word end (word_done high,
//           out_char zero). Word ends are only sent for nonempty words.
// cfg     : register writes, always ready: 0 escape_char, 1 quote_chars
//           (four packed bytes), 2 space_chars (eight packed bytes); zero
//           bytes are unused slots. Other indexes are dropped. Write only
//           while no beat is in flight.
// Timing  : one input beat per cycle sustained while word_out.ready is high.
//           Decode is one level of byte compares against the registers and
//           the state; the result lands in the output register.
// Stall   : the output register holds while word_out.ready is low; text_in
//           stays ready as long as the register is empty or draining.
// Reset   : rst (synchronous) restores the register defaults, clears the
//           escape, quote and word state and empties the output register.
module quoted_word_tokenizer_unit #(
  parameter int QUOTE_SLOTS = 4,
  parameter int SPACE_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  qwt_cfg_if.sink   cfg,
  qwt_in_if.sink    text_in,
  qwt_out_if.source word_out
);
  import qwt_pkg::*;

  // configuration registers
  logic [CHAR_W-1:0]  escape_char;
  logic [QUOTE_W-1:0] quote_chars;
  logic [SPACE_W-1:0] space_chars;

  // tokenizer state
  logic              escape_pending, escape_pending_next;
  logic [CHAR_W-1:0] open_quote, open_quote_next;
  logic              word_nonempty, word_nonempty_next;

  // output register
  result_t res, res_next;

  logic                  in_fire;
  logic                  is_eot;
  logic                  quote_hit;
  logic                  space_hit;
  logic [SLOT_EXT_W-1:0] quote_ext;
  logic [SLOT_EXT_W-1:0] space_ext;
  result_t               step;

  assign cfg.ready     = 1'b1;
  assign text_in.ready = !res.valid || word_out.ready;
  assign in_fire       = text_in.valid && text_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_char <= ESCAPE_CHAR_RESET;
      quote_chars <= QUOTE_CHARS_RESET;
      space_chars <= SPACE_CHARS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ESCAPE_CHAR: escape_char <= cfg.data[CHAR_W-1:0];
        REG_QUOTE_CHARS: quote_chars <= cfg.data[QUOTE_W-1:0];
        REG_SPACE_CHARS: space_chars <= cfg.data[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  // slots past the register width read as zero, i.e. unused
  assign quote_ext = {{(SLOT_EXT_W-QUOTE_W){1'b0}}, quote_chars};
  assign space_ext = space_chars[SLOT_EXT_W-1:0];

  always_comb begin
    quote_hit = 1'b0;
    for (int i = 0; i < QUOTE_SLOTS && i < MAX_SLOTS; i++) begin
      if (quote_ext[CHAR_W*i +: CHAR_W] != NUL_CHAR &&
          quote_ext[CHAR_W*i +: CHAR_W] == text_in.ch) begin
        quote_hit = 1'b1;
      end
    end
  end

  always_comb begin
    space_hit = 1'b0;
    for (int i = 0; i < SPACE_SLOTS && i < MAX_SLOTS; i++) begin
      if (space_ext[CHAR_W*i +: CHAR_W] != NUL_CHAR &&
          space_ext[CHAR_W*i +: CHAR_W] == text_in.ch) begin
        space_hit = 1'b1;
      end
    end
  end

  assign is_eot = text_in.is_end || (text_in.ch == NUL_CHAR);

  // Priority: end of text, pending escape, escape byte, open quote,
  // quote open, whitespace, plain character.
  always_comb begin
    escape_pending_next = escape_pending;
    open_quote_next     = open_quote;
    word_nonempty_next  = word_nonempty;
    step.valid          = 1'b0;
    step.out_char       = text_in.ch;
    step.word_done      = 1'b0;
    if (is_eot) begin
      step.valid          = word_nonempty;
      step.out_char       = NUL_CHAR;
      step.word_done      = 1'b1;
      escape_pending_next = 1'b0;
      open_quote_next     = NUL_CHAR;
      word_nonempty_next  = 1'b0;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      step.valid          = 1'b1;
      word_nonempty_next  = 1'b1;
    end else if (escape_char != NUL_CHAR && text_in.ch == escape_char) begin
      escape_pending_next = 1'b1;
    end else if (open_quote != NUL_CHAR) begin
      if (text_in.ch == open_quote) begin
        // closing quote ends the word
        open_quote_next    = NUL_CHAR;
        step.valid         = word_nonempty;
        step.out_char      = NUL_CHAR;
        step.word_done     = 1'b1;
        word_nonempty_next = 1'b0;
      end else begin
        step.valid         = 1'b1;
        word_nonempty_next = 1'b1;
      end
    end else if (quote_hit) begin
      open_quote_next = text_in.ch;
    end else if (space_hit) begin
      step.valid         = word_nonempty;
      step.out_char      = NUL_CHAR;
      step.word_done     = 1'b1;
      word_nonempty_next = 1'b0;
    end else begin
      step.valid         = 1'b1;
      word_nonempty_next = 1'b1;
    end
  end

  always_comb begin
    res_next = res;
    if (word_out.ready) begin
      res_next.valid = 1'b0;
    end
    if (in_fire && step.valid) begin
      res_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      open_quote     <= NUL_CHAR;
      word_nonempty  <= 1'b0;
      res.valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        escape_pending <= escape_pending_next;
        open_quote     <= open_quote_next;
        word_nonempty  <= word_nonempty_next;
      end
      res.valid <= res_next.valid;
    end
    // payload needs no reset
    res.out_char  <= res_next.out_char;
    res.word_done <= res_next.word_done;
  end

  assign word_out.valid     = res.valid;
  assign word_out.out_char  = res.out_char;
  assign word_out.word_done = res.word_done;

endmodule

// ===== hw/rtl/qwt_checker.sv =====
`timescale 1ns / 1ps
`include "quoted_word_tokenizer_unit_defines.svh"

module qwt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [qwt_pkg::CHAR_W-1:0] out_char,
  input logic                      word_done
);
  import qwt_pkg::*;

  // word end beats carry no character
  `QWT_ASSERT_NOW(a_done_no_char, out_valid && word_done, out_char == NUL_CHAR)

  // character beats never carry the zero byte
  `QWT_ASSERT_NOW(a_char_nonzero, out_valid && !word_done, out_char != NUL_CHAR)

  // input side is open whenever the output register is empty or draining
  `QWT_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready)

  // stalled result holds
  `QWT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(out_char) && $stable(word_done))

endmodule

bind quoted_word_tokenizer_unit qwt_checker u_qwt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text_in.valid),
  .in_ready  (text_in.ready),
  .out_valid (word_out.valid),
  .out_ready (word_out.ready),
  .out_char  (word_out.out_char),
  .word_done (word_out.word_done)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import qwt_pkg::*;

  localparam int CLK_HALF     = 6;     // 12 ns period
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT     = 28;    // percent of cycles each side holds off
  localparam int DRAIN_CYCLES = 4;     // output is registered, leave margin
  localparam int QUIET_LIMIT  = 1000;  // cycles with no beat anywhere before giving up
  localparam int QUOTE_SLOTS  = 4;
  localparam int SPACE_SLOTS  = 8;

  // Index the block must drop.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              word_done;
  } token_t;

  // Tracks the tokenizer state and the word_out beats still owed.
  class token_scoreboard;
    logic [CHAR_W-1:0]  esc_char;
    logic [QUOTE_W-1:0] quote_chars;
    logic [SPACE_W-1:0] space_chars;
    bit                 esc_pending;
    logic [CHAR_W-1:0]  open_q;
    bit                 word_open;
    token_t             expected_tokens[$];
    int                 errors;
    int                 checked;

    function new();
      esc_char    = ESCAPE_CHAR_RESET;
      quote_chars = QUOTE_CHARS_RESET;
      space_chars = SPACE_CHARS_RESET;
      esc_pending = 1'b0;
      open_q      = NUL_CHAR;
      word_open   = 1'b0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ESCAPE_CHAR: esc_char = value[CHAR_W-1:0];
        REG_QUOTE_CHARS: quote_chars = value[QUOTE_W-1:0];
        REG_SPACE_CHARS: space_chars = value[SPACE_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero bytes are empty slots and never match.
    function bit slot_has(logic [SLOT_EXT_W-1:0] packed_bytes, int slots,
                          logic [CHAR_W-1:0] c);
      for (int i = 0; i < slots && i < MAX_SLOTS; i++) begin
        if (packed_bytes[i*CHAR_W +: CHAR_W] != NUL_CHAR &&
            packed_bytes[i*CHAR_W +: CHAR_W] == c)
          return 1'b1;
      end
      return 1'b0;
    endfunction

    function void append_byte(logic [CHAR_W-1:0] c);
      expected_tokens.push_back('{out_char: c, word_done: 1'b0});
      word_open = 1'b1;
    endfunction

    function void close_word();
      if (word_open)
        expected_tokens.push_back('{out_char: NUL_CHAR, word_done: 1'b1});
      word_open = 1'b0;
    endfunction

    // One accepted text_in beat.
    function void take_char(logic [CHAR_W-1:0] c, logic is_end);
      if (is_end || c == NUL_CHAR) begin
        close_word();
        esc_pending = 1'b0;
        open_q      = NUL_CHAR;
        return;
      end
      if (esc_pending) begin
        esc_pending = 1'b0;
        append_byte(c);
        return;
      end
      if (esc_char != NUL_CHAR && c == esc_char) begin
        esc_pending = 1'b1;
        return;
      end
      if (open_q != NUL_CHAR) begin
        if (c == open_q) begin
          open_q = NUL_CHAR;
          close_word();
        end else begin
          append_byte(c);
        end
        return;
      end
      // quote meaning wins over whitespace
      if (slot_has({{(SLOT_EXT_W-QUOTE_W){1'b0}}, quote_chars}, QUOTE_SLOTS, c)) begin
        open_q = c;
        return;
      end
      if (slot_has(space_chars, SPACE_SLOTS, c))
        close_word();
      else
        append_byte(c);
    endfunction

    // One accepted word_out beat.
    function void check_token(logic [CHAR_W-1:0] oc, logic wd);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $error("word_out beat with nothing expected: out_char %02h word_done %0b", oc, wd);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (oc !== want.out_char) begin
        $error("out_char mismatch: expected %02h, got %02h", want.out_char, oc);
        errors++;
      end
      if (wd !== want.word_done) begin
        $error("word_done mismatch: expected %0b, got %0b", want.word_done, wd);
        errors++;
      end
    endfunction

    function void report_leftover();
      if (expected_tokens.size() != 0) begin
        $error("%0d word_out beats never arrived", expected_tokens.size());
        errors += expected_tokens.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_pct = IDLE_PCT;
  int   chars_sent = 0;
  int   settings_run = 1;   // reset defaults count as the first
  int   quiet_cycles = 0;
  token_scoreboard sb;

  qwt_cfg_if cfg_bus ();
  qwt_in_if  text_bus ();
  qwt_out_if word_bus ();

  quoted_word_tokenizer_unit #(
    .QUOTE_SLOTS(QUOTE_SLOTS),
    .SPACE_SLOTS(SPACE_SLOTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .text_in (text_bus),
    .word_out(word_bus)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Byte pickers. They read the current register copy in the scoreboard so the
  // random text actually hits the configured quote, space and escape bytes.
  // ---------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] word_byte();
    if ($urandom_range(99) < 60)
      return 8'h61 + 8'($urandom_range(25));   // lowercase letter
    return 8'($urandom_range(1, 255));
  endfunction

  // Random nonzero slot, or a plain byte when every slot is empty.
  function automatic logic [CHAR_W-1:0] slot_pick(logic [SLOT_EXT_W-1:0] packed_bytes,
                                                  int slots);
    int                first;
    logic [CHAR_W-1:0] b;
    first = $urandom_range(slots - 1);
    for (int k = 0; k < slots; k++) begin
      b = packed_bytes[((first + k) % slots)*CHAR_W +: CHAR_W];
      if (b != NUL_CHAR)
        return b;
    end
    return word_byte();
  endfunction

  function automatic logic [CHAR_W-1:0] quote_byte();
    return slot_pick({{(SLOT_EXT_W-QUOTE_W){1'b0}}, sb.quote_chars}, QUOTE_SLOTS);
  endfunction

  function automatic logic [CHAR_W-1:0] space_byte();
    return slot_pick(sb.space_chars, SPACE_SLOTS);
  endfunction

  function automatic logic [CHAR_W-1:0] escape_byte();
    return (sb.esc_char != NUL_CHAR) ? sb.esc_char : word_byte();
  endfunction

  // ---------------------------------------------------------------------------
  // text_in driver. valid stays high from one beat to the next unless a gap is
  // rolled, so it never sees two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_char(logic [CHAR_W-1:0] c, logic e);
    while ($urandom_range(99) < idle_pct) begin
      text_bus.valid <= 1'b0;
      @(posedge clk);
    end
    text_bus.valid  <= 1'b1;
    text_bus.ch     <= c;
    text_bus.is_end <= e;
    do @(posedge clk); while (!text_bus.ready);
    sb.take_char(c, e);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], 1'b0);
  endtask

  task automatic send_escaped();
    if (sb.esc_char != NUL_CHAR) begin
      send_char(sb.esc_char, 1'b0);
      send_char(8'($urandom_range(1, 255)), 1'b0);
    end else begin
      send_char(word_byte(), 1'b0);
    end
  endtask

  task automatic send_plain();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(9) == 0)
        send_escaped();
      else
        send_char(word_byte(), 1'b0);
    end
  endtask

  // Quoted span; sometimes empty, sometimes left open for the next segment.
  task automatic send_quoted();
    logic [CHAR_W-1:0] q;
    q = quote_byte();
    send_char(q, 1'b0);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(5))
        0:       send_escaped();
        1:       send_char(space_byte(), 1'b0);
        default: send_char(word_byte(), 1'b0);
      endcase
    end
    if ($urandom_range(99) < 88)
      send_char(q, 1'b0);
  endtask

  // Mostly well-formed lines: words of plain and quoted segments separated by
  // whitespace, closed by an end beat. About one in seven is noise.
  task automatic send_sentence();
    logic [CHAR_W-1:0] c;
    int                r;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(3))
          0:       c = quote_byte();
          1:       c = space_byte();
          2:       c = escape_byte();
          default: c = 8'($urandom_range(255));
        endcase
        send_char(c, $urandom_range(19) == 0);
      end
      return;
    end
    for (int w = $urandom_range(1, 5); w > 0; w--) begin
      repeat ($urandom_range(0, 2))
        send_char(space_byte(), 1'b0);
      for (int s = $urandom_range(1, 3); s > 0; s--) begin
        if ($urandom_range(99) < 35)
          send_quoted();
        else
          send_plain();
      end
    end
    r = $urandom_range(99);
    if (r < 80)
      send_char(8'($urandom_range(255)), 1'b1);  // end beat, ch ignored
    else if (r < 88)
      send_char(NUL_CHAR, 1'b0);                 // zero byte acts as end
  endtask

  task automatic random_text(int n_items);
    int stop_at;
    stop_at = chars_sent + n_items;
    while (chars_sent < stop_at)
      send_sentence();
  endtask

  // Drop valid, wait for every owed beat, then let the pipe empty.
  task automatic settle();
    text_bus.valid <= 1'b0;
    while (sb.expected_tokens.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, value);
  endtask

  // Junk in the unused upper data bits checks that the block masks them.
  task automatic load_setting(logic [CHAR_W-1:0] esc, logic [QUOTE_W-1:0] quotes,
                              logic [SPACE_W-1:0] spaces);
    settle();
    write_reg(REG_ESCAPE_CHAR, {$urandom, 24'($urandom), esc});
    write_reg(REG_QUOTE_CHARS, {$urandom, quotes});
    write_reg(REG_SPACE_CHARS, spaces);
    cfg_bus.valid <= 1'b0;
    settings_run++;
  endtask

  // word_out sink: random back-pressure, check every beat taken.
  initial begin
    word_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && word_bus.valid && word_bus.ready)
        sb.check_token(word_bus.out_char, word_bus.word_done);
      word_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: too long with no beat on any channel means a hang.
  always @(posedge clk) begin
    if ((text_bus.valid && text_bus.ready) || (word_bus.valid && word_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("quoted_word_tokenizer_unit test failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    text_bus.valid  = 1'b0;
    text_bus.ch     = NUL_CHAR;
    text_bus.is_end = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_ESCAPE_CHAR;
    cfg_bus.data    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset registers: backslash escape, single and double quotes.
    send_text("ab ");                           // plain word, space ends it
    send_char(8'hFF, 1'b0);                     // extreme codes as word bytes
    send_char(8'h01, 1'b0);
    send_text("\" x\"");                        // quote mid-word; close ends word
    send_text("''");                            // empty quotes: no beat at all
    send_text("\\\"");                          // escaped quote is literal
    send_text("\"\\\"\"");                      // escape inside quotes, then close
    send_text("\\");
    send_char(8'h71, 1'b1);                     // end drops a pending escape
    send_text("'z");
    send_char(NUL_CHAR, 1'b1);                  // end closes word inside open quote
    send_char(8'h6B, 1'b0);
    send_char(NUL_CHAR, 1'b0);                  // bare zero byte behaves as end
    send_text("  ");
    send_char(8'hFF, 1'b1);                     // end with nothing pending
    random_text(110);

    // Escaping off, one quote in slot 0, one space in the top slot.
    load_setting(8'h00, 32'h0000_0060, 64'h2000_0000_0000_0000);
    random_text(90);

    // All ones: escape shadows every quote and space byte.
    load_setting(8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    random_text(60);

    // Double quote is also whitespace; the quote meaning has to win.
    load_setting(8'h01, 32'h2700_0022, 64'h0922_0000_2C00_203B);
    send_text("a\"b\"");
    // stretch with no idling on either side
    idle_pct = 0;
    random_text(150);
    idle_pct = IDLE_PCT;

    // No whitespace at all, four quote bytes.
    load_setting(8'h2F, 32'h7C5B_2722, 64'h0);
    random_text(90);

    // No quotes, every space slot used.
    load_setting(ESCAPE_CHAR_RESET, 32'h0, 64'h0D0A_0920_2C2E_3A3B);
    random_text(90);

    repeat (2) begin
      load_setting(8'($urandom), $urandom, {$urandom, $urandom});
      random_text(80);
    end

    // Back to the reset values; a write to the spare index must change nothing.
    load_setting(ESCAPE_CHAR_RESET, QUOTE_CHARS_RESET, SPACE_CHARS_RESET);
    settle();
    write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_bus.valid <= 1'b0;
    random_text(100);

    settle();
    sb.report_leftover();
    $display("Ran %0d characters through %0d register settings, %0d word_out beats checked.",
             chars_sent, settings_run, sb.checked);
    $display("Covered escapes, quoted spans, quote/space overlap, empty and full slots, ends.");
    if (sb.errors == 0)
      $display("quoted_word_tokenizer_unit test passed");
    else
      $display("quoted_word_tokenizer_unit test failed");
    $finish;
  end

endmodule
